// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int CFG_ADDR_W = 3;

    localparam logic [7:0] WILD_BYTE  = 8'h2A;
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FIND_PATTERN    = 3'd0,
        CFG_FIND_LENGTH     = 3'd1,
        CFG_REPLACE_PATTERN = 3'd2,
        CFG_REPLACE_LENGTH  = 3'd3,
        CFG_WILDCARD_ENABLE = 3'd4
    } sfr_cfg_idx_t;

    typedef struct packed {
        logic [63:0] find_pattern;
        logic [3:0]  find_length;
        logic [63:0] replace_pattern;
        logic [3:0]  replace_length;
        logic        wildcard_enable;
    } sfr_cfg_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       has_char;
        logic       is_last;
    } sfr_in_t;

    typedef struct packed {
        logic [7:0]  char_out;
        logic        char_valid;
        logic        end_of_string;
        logic [15:0] replace_count;
    } sfr_out_t;

    // per-batch control carried from the step logic to the output queue
    typedef struct packed {
        logic        char_valid;
        logic        end_of_string;
        logic [15:0] replace_count;
    } sfr_batch_ctrl_t;

endpackage

// File: rtl/stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace: input buffer register, then result register, to the first result
// throughput 1 input per cycle unless the queue stalls; N results hold the queue for N transactions
// reset (aresetn, synchronous, active low) empties window, count, buffers and registers
// ----------------------------------------------------------------------------
module stream_find_and_replace
    import sfr_pkg::*;
#(
    parameter int MAX_FIND_LEN    = 8,
    parameter int MAX_REPLACE_LEN = 8,
    parameter int COUNT_BITS      = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [63:0]           cfg_data,
    // input byte stream
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sfr_in_t               s_data,
    // result stream
    output logic                  m_valid,
    input  logic                  m_ready,
    output sfr_out_t              m_data
);

    localparam int BD = MAX_FIND_LEN + MAX_REPLACE_LEN;
    localparam int NW = $clog2(BD + 1);

    // configuration registers, always writable
    sfr_cfg_t cfg_reg, cfg_next;

    // skid buffer to step logic
    logic    buf_valid, buf_ready;
    sfr_in_t buf_data;

    // step logic to output queue
    logic               batch_load, out_free;
    logic [BD-1:0][7:0] batch_bytes;
    logic [NW-1:0]      batch_count;
    sfr_batch_ctrl_t    batch_ctrl;

    assign cfg_ready = 1'b1;

    // register write decode; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_FIND_PATTERN:    cfg_next.find_pattern    = cfg_data;
                CFG_FIND_LENGTH:     cfg_next.find_length     = cfg_data[3:0];
                CFG_REPLACE_PATTERN: cfg_next.replace_pattern = cfg_data;
                CFG_REPLACE_LENGTH:  cfg_next.replace_length  = cfg_data[3:0];
                CFG_WILDCARD_ENABLE: cfg_next.wildcard_enable = cfg_data[0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // input transactions land here so s_ready never waits on m_ready
    sfr_in_buf u_in_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .out_valid (buf_valid),
        .out_ready (buf_ready),
        .out_data  (buf_data)
    );

    // window update, compare, result batch; one input per cycle unless the queue stalls
    sfr_step #(
        .MAX_FIND_LEN    (MAX_FIND_LEN),
        .MAX_REPLACE_LEN (MAX_REPLACE_LEN),
        .COUNT_BITS      (COUNT_BITS)
    ) u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (buf_valid),
        .in_ready    (buf_ready),
        .in_data     (buf_data),
        .out_free    (out_free),
        .batch_load  (batch_load),
        .batch_bytes (batch_bytes),
        .batch_count (batch_count),
        .batch_ctrl  (batch_ctrl)
    );

    // result register; drains longer replacements one byte per transaction
    sfr_out_queue #(
        .MAX_FIND_LEN    (MAX_FIND_LEN),
        .MAX_REPLACE_LEN (MAX_REPLACE_LEN)
    ) u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (batch_load),
        .load_bytes (batch_bytes),
        .load_count (batch_count),
        .load_ctrl  (batch_ctrl),
        .free       (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// File: rtl/sfr_in_buf.sv
// ----------------------------------------------------------------------------
// sfr_in_buf
// Two-entry input skid buffer; ready comes straight from a register.
// ----------------------------------------------------------------------------
module sfr_in_buf
    import sfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  sfr_in_t s_data,
    output logic    out_valid,
    input  logic    out_ready,
    output sfr_in_t out_data
);

    logic [1:0] count_reg, count_next;
    sfr_in_t    entry0_reg, entry0_next;
    sfr_in_t    entry1_reg, entry1_next;
    logic       push, pop;

    assign s_ready   = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry0_reg;
    assign push      = s_valid && s_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next  = count_reg;
        entry0_next = entry0_reg;
        entry1_next = entry1_reg;
        case (count_reg)
            2'd0: begin
                if (push) begin
                    entry0_next = s_data;
                    count_next  = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    entry0_next = s_data;
                end else if (push) begin
                    entry1_next = s_data;
                    count_next  = 2'd2;
                end else if (pop) begin
                    count_next  = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    entry0_next = entry1_reg;
                    count_next  = 2'd1;
                end
            end
            default: begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        entry0_reg <= entry0_next;
        entry1_reg <= entry1_next;
    end

endmodule

// File: rtl/sfr_step.sv
// ----------------------------------------------------------------------------
// sfr_step
// Pending-byte window, pattern compare and result batch for one transaction.
// ----------------------------------------------------------------------------
module sfr_step
    import sfr_pkg::*;
#(
    parameter int MAX_FIND_LEN    = 8,
    parameter int MAX_REPLACE_LEN = 8,
    parameter int COUNT_BITS      = 16,
    localparam int BD = MAX_FIND_LEN + MAX_REPLACE_LEN,
    localparam int NW = $clog2(BD + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sfr_cfg_t                 cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  sfr_in_t                  in_data,
    input  logic                     out_free,
    output logic                     batch_load,
    output logic [BD-1:0][7:0]       batch_bytes,
    output logic [NW-1:0]            batch_count,
    output sfr_batch_ctrl_t          batch_ctrl
);

    localparam int DEPTH = MAX_FIND_LEN;
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DEPTH-1:0][7:0]  win_reg, win_next;
    logic [FW-1:0]          fill_reg, fill_next;
    logic [COUNT_BITS-1:0]  total_reg, total_next;

    logic [DEPTH-1:0][7:0]  w2, w3;
    logic [3:0]             flen, rlen, f2, f3, drop, head, tail;
    logic                   appended, match, do_rep, emit_one, needs_out, fire;
    logic [COUNT_BITS-1:0]  total_inc;

    always_comb begin
        flen = (cfg.find_length > 4'(MAX_FIND_LEN)) ? 4'(MAX_FIND_LEN) : cfg.find_length;
        rlen = (cfg.replace_length > 4'(MAX_REPLACE_LEN)) ? 4'(MAX_REPLACE_LEN)
                                                          : cfg.replace_length;

        // append the new byte at the fill point
        appended = in_data.has_char && (4'(fill_reg) < 4'(DEPTH));
        w2 = win_reg;
        if (appended) begin
            w2[IW'(fill_reg)] = in_data.char_in;
        end
        f2 = 4'(fill_reg) + {3'b000, appended};

        // compare the oldest bytes against the pattern
        match = 1'b1;
        for (int k = 0; k < DEPTH; k++) begin
            if (4'(k) < flen) begin
                if (!((cfg.wildcard_enable && cfg.find_pattern[8*k +: 8] == WILD_BYTE
                       && w2[k] != SPACE_BYTE) || w2[k] == cfg.find_pattern[8*k +: 8])) begin
                    match = 1'b0;
                end
            end
        end

        do_rep   = appended && (flen != 4'd0) && (f2 >= flen) && match;
        emit_one = appended && ((flen == 4'd0) || ((f2 >= flen) && !match));
        drop     = do_rep ? flen : (emit_one ? 4'd1 : 4'd0);
        f3       = f2 - drop;
        head     = do_rep ? rlen : (emit_one ? 4'd1 : 4'd0);
        tail     = in_data.is_last ? f3 : 4'd0;

        for (int i = 0; i < DEPTH; i++) begin
            if (i + int'(drop) < DEPTH) begin
                w3[i] = w2[IW'(i + int'(drop))];
            end else begin
                w3[i] = '0;
            end
        end

        // batch bytes: head (replacement or oldest byte) then the flushed tail
        for (int i = 0; i < BD; i++) begin
            if (do_rep) begin
                if (4'(i) < rlen) begin
                    batch_bytes[i] = cfg.replace_pattern[8*(i % 8) +: 8];
                end else if (i - int'(rlen) < DEPTH) begin
                    batch_bytes[i] = w3[IW'(i - int'(rlen))];
                end else begin
                    batch_bytes[i] = '0;
                end
            end else if (i < DEPTH) begin
                batch_bytes[i] = w2[IW'(i)];
            end else begin
                batch_bytes[i] = '0;
            end
        end

        total_inc = (do_rep && (total_reg != '1)) ? total_reg + 1'b1 : total_reg;

        needs_out   = (head != 4'd0) || in_data.is_last;
        batch_count = NW'(head) + NW'(tail);
        batch_ctrl.char_valid    = 1'b1;
        if (in_data.is_last && (head == 4'd0) && (tail == 4'd0)) begin
            // nothing to flush: a lone marker result
            batch_count           = NW'(1);
            batch_ctrl.char_valid = 1'b0;
        end
        batch_ctrl.end_of_string = in_data.is_last;
        batch_ctrl.replace_count = 16'(total_inc);

        in_ready   = out_free || !needs_out;
        fire       = in_valid && in_ready;
        batch_load = fire && needs_out;

        win_next   = w3;
        fill_next  = in_data.is_last ? '0 : FW'(f3);
        total_next = in_data.is_last ? '0 : total_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            total_reg <= '0;
        end else if (fire) begin
            fill_reg  <= fill_next;
            total_reg <= total_next;
        end
        if (fire) begin
            win_reg <= win_next;
        end
    end

`ifndef SYNTHESIS
    a_fill_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < FW'(DEPTH))
        else $error("window fill beyond depth");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_data.is_last) |=> (fill_reg == '0) && (total_reg == '0))
        else $error("window or count not cleared at end of string");

    a_batch_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        batch_load |-> (batch_count != '0))
        else $error("result batch loaded with no results");
`endif

endmodule

// File: rtl/sfr_out_queue.sv
// ----------------------------------------------------------------------------
// sfr_out_queue
// Holds one result batch and drains it one result per transaction.
// ----------------------------------------------------------------------------
module sfr_out_queue
    import sfr_pkg::*;
#(
    parameter int MAX_FIND_LEN    = 8,
    parameter int MAX_REPLACE_LEN = 8,
    localparam int BD = MAX_FIND_LEN + MAX_REPLACE_LEN,
    localparam int NW = $clog2(BD + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic [BD-1:0][7:0] load_bytes,
    input  logic [NW-1:0]      load_count,
    input  sfr_batch_ctrl_t    load_ctrl,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output sfr_out_t           m_data
);

    logic [BD-1:0][7:0] bytes_reg, bytes_next;
    logic [NW-1:0]      left_reg, left_next;
    sfr_batch_ctrl_t    ctrl_reg, ctrl_next;
    logic               take, last_beat;

    assign m_valid   = (left_reg != '0);
    assign take      = m_valid && m_ready;
    assign last_beat = (left_reg == NW'(1));
    assign free      = !m_valid || (last_beat && m_ready);

    always_comb begin
        bytes_next = bytes_reg;
        left_next  = left_reg;
        ctrl_next  = ctrl_reg;
        if (load) begin
            bytes_next = load_bytes;
            left_next  = load_count;
            ctrl_next  = load_ctrl;
        end else if (take) begin
            for (int i = 0; i < BD - 1; i++) begin
                bytes_next[i] = bytes_reg[i+1];
            end
            bytes_next[BD-1] = '0;
            left_next        = left_reg - NW'(1);
        end
    end

    always_comb begin
        m_data.char_out      = ctrl_reg.char_valid ? bytes_reg[0] : 8'h00;
        m_data.char_valid    = ctrl_reg.char_valid;
        m_data.end_of_string = ctrl_reg.end_of_string && last_beat;
        m_data.replace_count = m_data.end_of_string ? ctrl_reg.replace_count : 16'h0000;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else begin
            left_reg <= left_next;
        end
        bytes_reg <= bytes_next;
        ctrl_reg  <= ctrl_next;
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("batch loaded over pending results");

    a_drain_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !last_beat && !load) |=> (left_reg == $past(left_reg) - NW'(1)))
        else $error("result count did not step down by one");

    a_marker_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.char_valid) |-> m_data.end_of_string)
        else $error("empty result that is not end of string");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stream find-and-replace testbench
// Drives byte transactions and register writes with random gaps and stalls,
// predicts the rewritten byte stream and end-of-string counts, and compares
// every result transaction against the prediction field by field.
// ----------------------------------------------------------------------------
module tb;
    import sfr_pkg::*;

    localparam int unsigned MAX_FIND     = 8;
    localparam int unsigned MAX_REPLACE  = 8;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
    localparam int unsigned RANDOM_ITEMS = 330;
    localparam int unsigned RUN_BYTES    = 48;
    // bytes held in the window produce nothing, so give slack
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned REPORT_MAX   = 10;

    // clock, reset and dut ports, all inputs known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [63:0]           cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    sfr_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    sfr_out_t              m_data;

    // shadow of the register file
    logic [63:0] find_pat  = '0;
    logic [3:0]  find_len  = '0;
    logic [63:0] repl_pat  = '0;
    logic [3:0]  repl_len  = '0;
    logic        wild_on   = 1'b0;

    // shadow of the pending-byte window and the replacement tally
    logic [7:0]  win_bytes [8] = '{default: '0};
    int unsigned win_fill   = 0;
    logic [15:0] repl_total = '0;

    // rewritten stream still owed by the dut, oldest first
    sfr_out_t    rewritten_q[$];
    sfr_out_t    want_res;

    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned cycle_count    = 0;
    int unsigned sink_hold      = 0;
    bit          steady         = 1'b0;

    stream_find_and_replace i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // 8 ns period
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic int unsigned eff_find_len();
        return (find_len > MAX_FIND) ? MAX_FIND : find_len;
    endfunction

    function automatic sfr_out_t text_result(logic [7:0] ch);
        return '{char_out: ch, char_valid: 1'b1, end_of_string: 1'b0, replace_count: '0};
    endfunction

    // pattern compare over the oldest flen window bytes
    function automatic bit window_hit(int unsigned flen);
        logic [7:0] p;
        for (int k = 0; k < flen; k++) begin
            p = find_pat[8*k +: 8];
            // wildcard matches anything but a space
            if (wild_on && p == WILD_BYTE && win_bytes[k] != SPACE_BYTE)
                continue;
            if (win_bytes[k] != p)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void shift_window(int unsigned n);
        if (n >= win_fill) begin
            win_fill = 0;
        end else begin
            for (int k = 0; k + n < win_fill; k++)
                win_bytes[k] = win_bytes[k + n];
            win_fill -= n;
        end
    endfunction

    // works out the results of one accepted transaction and queues them
    function automatic void rewrite_char(sfr_in_t item);
        sfr_out_t    step_q[$];
        sfr_out_t    res;
        int unsigned flen;
        int unsigned rlen;
        flen = eff_find_len();
        rlen = (repl_len > MAX_REPLACE) ? MAX_REPLACE : repl_len;
        if (item.has_char && win_fill < 8) begin
            win_bytes[win_fill] = item.char_in;
            win_fill++;
            if (flen == 0) begin
                // matching off: straight pass-through (window may still hold bytes)
                step_q.push_back(text_result(win_bytes[0]));
                shift_window(1);
            end else if (win_fill >= flen) begin
                if (window_hit(flen)) begin
                    for (int k = 0; k < rlen; k++)
                        step_q.push_back(text_result(repl_pat[8*k +: 8]));
                    shift_window(flen);
                    if (repl_total != COUNT_MAX)
                        repl_total++;
                end else begin
                    step_q.push_back(text_result(win_bytes[0]));
                    shift_window(1);
                end
            end
        end
        if (item.is_last) begin
            // flush leftovers unchanged, never matched against the pattern
            for (int k = 0; k < win_fill; k++)
                step_q.push_back(text_result(win_bytes[k]));
            if (step_q.size() == 0)
                step_q.push_back('0);
            res = step_q.pop_back();
            res.end_of_string = 1'b1;
            res.replace_count = repl_total;
            step_q.push_back(res);
            win_bytes  = '{default: '0};
            win_fill   = 0;
            repl_total = '0;
        end
        foreach (step_q[k])
            rewritten_q.push_back(step_q[k]);
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // bytes that tend to hit patterns, plus the odd random one
    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 5))
            0:       return "a";
            1:       return "b";
            2:       return WILD_BYTE;
            3:       return SPACE_BYTE;
            4:       return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [63:0] pack_text(string txt);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < txt.len() && k < 8; k++)
            v[8*k +: 8] = txt[k];
        return v;
    endfunction

    // ------------------------------------------------------------------
    // result checker and output stalls
    // ------------------------------------------------------------------

    function automatic void log_mismatch(string why, sfr_out_t want, sfr_out_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t %s: char/valid/eos/count expected %02h %b %b %0d, got %02h %b %b %0d",
                     $realtime, why, want.char_out, want.char_valid, want.end_of_string,
                     want.replace_count, got.char_out, got.char_valid, got.end_of_string,
                     got.replace_count);
    endfunction

    // every accepted result transaction is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (rewritten_q.size() == 0) begin
                log_mismatch("unexpected result", '0, m_data);
            end else begin
                want_res = rewritten_q.pop_front();
                if (m_data.char_out !== want_res.char_out
                        || m_data.char_valid !== want_res.char_valid
                        || m_data.end_of_string !== want_res.end_of_string
                        || m_data.replace_count !== want_res.replace_count)
                    log_mismatch("result mismatch", want_res, m_data);
            end
        end
    end

    // receiver back-pressure, off while steady is set
    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_ready   <= 1'b0;
        end else if (!steady && $urandom_range(0, 4) == 0) begin
            sink_hold <= pick_gap() - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // run limit
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge aclk);
        $display("timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one input transaction; valid stays high for a back-to-back follower
    task automatic send_char(logic [7:0] ch, bit has, bit eos);
        sfr_in_t     item;
        int unsigned gap;
        item = '{char_in: ch, has_char: has, is_last: eos};
        gap  = 0;
        if (!steady && $urandom_range(0, 9) < 3)
            gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rewrite_char(item);
        if (has || eos)
            items_sent++;
    endtask

    task automatic send_text(string txt, bit close);
        int unsigned n;
        n = txt.len();
        for (int k = 0; k < n; k++)
            send_char(txt[k], 1'b1, close && (k == n - 1));
    endtask

    // drop valid, let every owed result arrive, then cover the latency
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (rewritten_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // register write; only called with the block idle
    task automatic write_reg(sfr_cfg_idx_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FIND_PATTERN:    find_pat = value;
            CFG_FIND_LENGTH:     find_len = value[3:0];
            CFG_REPLACE_PATTERN: repl_pat = value;
            CFG_REPLACE_LENGTH:  repl_len = value[3:0];
            CFG_WILDCARD_ENABLE: wild_on  = value[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_setup(logic [63:0] fpat, logic [3:0] flen, logic [63:0] rpat,
                              logic [3:0] rlen, logic wild);
        write_reg(CFG_FIND_PATTERN, fpat);
        write_reg(CFG_FIND_LENGTH, 64'(flen));
        write_reg(CFG_REPLACE_PATTERN, rpat);
        write_reg(CFG_REPLACE_LENGTH, 64'(rlen));
        write_reg(CFG_WILDCARD_ENABLE, 64'(wild));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset setup: matching off, bytes pass straight through
    task automatic test_passthrough();
        send_char(8'hA5, 1'b0, 1'b0);   // idle step, no result
        send_char(8'h00, 1'b1, 1'b0);   // zero byte is an ordinary byte
        send_char(8'hFF, 1'b1, 1'b1);
        send_char(8'h5A, 1'b0, 1'b1);   // empty end marker -> blank result, count 0
        wait_drained();
    endtask

    // leftmost non-overlapping replacement with a longer replacement
    task automatic test_find_replace();
        load_setup(pack_text("ab"), 4'd2, pack_text("XYZ"), 4'd3, 1'b0);
        send_text("xabab", 1'b1);
        wait_drained();
    endtask

    // wildcard skips spaces; with the mode off only a literal star matches
    task automatic test_wildcard();
        load_setup(pack_text("a*c"), 4'd3, pack_text("#"), 4'd1, 1'b1);
        send_text("abca c", 1'b1);
        wait_drained();
        write_reg(CFG_WILDCARD_ENABLE, 64'(1'b0));
        send_text("a*cab", 1'b1);       // trailing partial match flushed as is
        wait_drained();
    endtask

    // oversized lengths clamp to 8; zero-length replacement leaves a blank end
    task automatic test_length_extremes();
        load_setup('1, 4'd15, '1, 4'd15, 1'b1);
        repeat (7) send_char(8'hFF, 1'b1, 1'b0);
        send_char(8'hFF, 1'b1, 1'b1);
        wait_drained();
        write_reg(CFG_FIND_LENGTH, 64'(4'd1));
        write_reg(CFG_REPLACE_LENGTH, 64'(4'd0));
        send_char(8'hFF, 1'b1, 1'b1);
        wait_drained();
    endtask

    // shrink the pattern under a held window; the flush must not match it
    task automatic test_midstring_reconfig();
        load_setup(pack_text("ab"), 4'd8, pack_text("Q"), 4'd1, 1'b0);
        send_text("ab", 1'b0);
        wait_drained();
        write_reg(CFG_FIND_LENGTH, 64'(4'd2));
        send_char(8'h00, 1'b0, 1'b1);
        wait_drained();
    endtask

    // one long string of back-to-back single-byte deletions, each one counted
    task automatic test_count_run();
        load_setup(pack_text("a"), 4'd1, '0, 4'd0, 1'b0);
        steady = 1'b1;
        for (int k = 0; k < RUN_BYTES; k++)
            send_char("a", 1'b1, k == RUN_BYTES - 1);
        wait_drained();
        steady = 1'b0;
    endtask

    task automatic random_setup();
        logic [63:0] fpat;
        logic [63:0] rpat;
        logic [3:0]  flen;
        logic [3:0]  rlen;
        case ($urandom_range(0, 9))
            0:       fpat = '0;
            1:       fpat = '1;
            default: for (int k = 0; k < 8; k++) fpat[8*k +: 8] = pick_letter();
        endcase
        case ($urandom_range(0, 9))
            0:       flen = 4'd0;
            1:       flen = 4'd8;
            2:       flen = 4'($urandom_range(9, 15));
            default: flen = 4'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 9))
            0:       rlen = 4'd0;
            1:       rlen = 4'd8;
            2:       rlen = 4'($urandom_range(9, 15));
            default: rlen = 4'($urandom_range(0, 4));
        endcase
        rpat = {$urandom, $urandom};
        load_setup(fpat, flen, rpat, rlen, 1'($urandom_range(0, 1)));
    endtask

    // a string built mostly from pattern copies, with noise and broken copies
    task automatic send_random_string();
        int unsigned chunks;
        int unsigned flen;
        int unsigned cut;
        logic [7:0]  ch;
        chunks = $urandom_range(1, 6);
        flen   = eff_find_len();
        for (int c = 0; c < chunks; c++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // full pattern copy, wildcards filled in, rarely corrupted
                    for (int k = 0; k < flen; k++) begin
                        ch = find_pat[8*k +: 8];
                        if (wild_on && ch == WILD_BYTE) begin
                            case ($urandom_range(0, 5))
                                0:       ch = SPACE_BYTE;
                                1:       ch = WILD_BYTE;
                                default: ch = 8'($urandom_range(0, 255));
                            endcase
                        end
                        if ($urandom_range(0, 15) == 0)
                            ch = 8'($urandom_range(0, 255));
                        send_char(ch, 1'b1, 1'b0);
                    end
                end
                4, 5, 6: send_char(pick_letter(), 1'b1, 1'b0);
                7:       send_char(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                8:       send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                default: begin
                    // truncated pattern prefix
                    cut = (flen == 0) ? 0 : $urandom_range(0, flen - 1);
                    for (int k = 0; k < cut; k++)
                        send_char(find_pat[8*k +: 8], 1'b1, 1'b0);
                end
            endcase
        end
        // end the string most of the time, sometimes leave it open across a reconfig
        case ($urandom_range(0, 7))
            0:       ;
            1, 2:    send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            default: send_char(pick_letter(), 1'b1, 1'b1);
        endcase
    endtask

    task automatic test_random_streams();
        int unsigned stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            random_setup();
            // some phases run with no gaps or stalls at all
            steady = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(2, 6)) send_random_string();
            wait_drained();
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_passthrough();
        test_find_replace();
        test_wildcard();
        test_length_extremes();
        test_midstring_reconfig();
        test_count_run();
        test_random_streams();
        wait_drained();
        if (rewritten_q.size() != 0) begin
            $display("%0d expected results never arrived", rewritten_q.size());
            mismatch_count += rewritten_q.size();
        end
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
rtl/sfr_pkg.sv
rtl/sfr_in_buf.sv
rtl/sfr_step.sv
rtl/sfr_out_queue.sv
rtl/stream_find_and_replace.sv
verif/tb.sv
